>>> src/pulse_width_command_decoder_defines.svh
// Assertion macros for the pulse width command decoder.
`ifndef PULSE_WIDTH_COMMAND_DECODER_DEFINES_SVH
`define PULSE_WIDTH_COMMAND_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that cond_b holds in the same cycle whenever cond_a holds.
`define PWCD_ASSERT_IMPLY(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("pwcd: same-cycle implication failed");
// Check that cond_b holds in the cycle after cond_a holds.
`define PWCD_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("pwcd: next-cycle implication failed");
`else
`define PWCD_ASSERT_IMPLY(label, clk, rst_n, cond_a, cond_b)
`define PWCD_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b)
`endif

`endif

>>> src/pwcd_pkg.sv
// Shared types, codes and constants of the pulse width command decoder.
package pwcd_pkg;

    localparam int WIDTH_W     = 16;
    localparam int CODE_W      = 3;
    localparam int ACT_W       = 3;
    localparam int STATE_W     = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // Operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Symbol codes
    localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_A    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_B    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_C    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_D    = 3'd4;

    // Command codes
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ON       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OFF      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PULSE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESERVED = 3'd4;

    // Sequence states
    localparam logic [STATE_W-1:0] ST_START = 3'd0;
    localparam logic [STATE_W-1:0] ST_A     = 3'd1;
    localparam logic [STATE_W-1:0] ST_AB    = 3'd2;
    localparam logic [STATE_W-1:0] ST_AC    = 3'd3;
    localparam logic [STATE_W-1:0] ST_ABB   = 3'd4;
    localparam logic [STATE_W-1:0] ST_ABC   = 3'd5;
    localparam logic [STATE_W-1:0] ST_ACB   = 3'd6;
    localparam logic [STATE_W-1:0] ST_ACC   = 3'd7;

    // Output modes
    localparam logic [MODE_W-1:0] MODE_LOW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_TIMEOUT = 1'd1;
    localparam logic [CFG_W-1:0]     PULSE_LENGTH_RST   = 8'd50;
    localparam logic [CFG_W-1:0]     DECODE_TIMEOUT_RST = 8'd250;

    // Code window bounds, exclusive at both ends
    localparam logic [WIDTH_W-1:0] WIN_A_LO = 16'h1000;
    localparam logic [WIDTH_W-1:0] WIN_A_HI = 16'h2000;
    localparam logic [WIDTH_W-1:0] WIN_B_LO = 16'h2000;
    localparam logic [WIDTH_W-1:0] WIN_B_HI = 16'h3000;
    localparam logic [WIDTH_W-1:0] WIN_C_LO = 16'h4000;
    localparam logic [WIDTH_W-1:0] WIN_C_HI = 16'h5000;
    localparam logic [WIDTH_W-1:0] WIN_D_LO = 16'h7000;
    localparam logic [WIDTH_W-1:0] WIN_D_HI = 16'h8000;

    typedef struct packed {
        logic               op;
        logic [WIDTH_W-1:0] width;
        logic               overflow;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [ACT_W-1:0]   action;
        logic               drive;
        logic [STATE_W-1:0] decoder_state;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

>>> src/pwcd_classify.sv
// Width classifier: maps a measured width onto symbol codes A to D by windows.
module pwcd_classify (
    input  logic [pwcd_pkg::WIDTH_W-1:0] i_width,
    output logic [pwcd_pkg::CODE_W-1:0]  o_code
);
    import pwcd_pkg::*;

    // Check each exclusive window, first match wins
    always_comb begin
        if (i_width > WIN_A_LO && i_width < WIN_A_HI) begin
            o_code = CODE_A;
        end else if (i_width > WIN_B_LO && i_width < WIN_B_HI) begin
            o_code = CODE_B;
        end else if (i_width > WIN_C_LO && i_width < WIN_C_HI) begin
            o_code = CODE_C;
        end else if (i_width > WIN_D_LO && i_width < WIN_D_HI) begin
            o_code = CODE_D;
        end else begin
            o_code = CODE_NONE;
        end
    end

endmodule

>>> src/pwcd_core.sv
// Decoder core: sequence state, timeout, output mode, pulse counter and config.
module pwcd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pwcd_pkg::t_cfg_wr i_cfg,
    input  logic              i_step,
    input  pwcd_pkg::t_item   i_item,
    output pwcd_pkg::t_result o_result
);
    import pwcd_pkg::*;

    logic [CFG_W-1:0]   r_pulse_length;
    logic [CFG_W-1:0]   r_decode_timeout;
    logic [STATE_W-1:0] r_seq, n_seq;
    logic [CFG_W-1:0]   r_timeout_left, n_timeout_left;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [CFG_W-1:0]   r_pulse_left, n_pulse_left;
    logic               r_pin, n_pin;
    logic [CODE_W-1:0]  class_code;
    logic [CODE_W-1:0]  code;
    logic [ACT_W-1:0]   action;
    logic [CFG_W-1:0]   timeout_dec;

    pwcd_classify u_classify (
        .i_width (i_item.width),
        .o_code  (class_code)
    );

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_length   <= PULSE_LENGTH_RST;
            r_decode_timeout <= DECODE_TIMEOUT_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_PULSE_LENGTH:   r_pulse_length   <= i_cfg.data;
                CFG_DECODE_TIMEOUT: r_decode_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Work out the next state and the result of one transaction
    always_comb begin
        n_seq          = r_seq;
        n_timeout_left = r_timeout_left;
        n_mode         = r_mode;
        n_pulse_left   = r_pulse_left;
        n_pin          = r_pin;
        code           = CODE_NONE;
        action         = ACT_NONE;
        timeout_dec    = (r_timeout_left != '0) ? r_timeout_left - CFG_W'(1) : r_timeout_left;

        if (i_item.op == OP_TICK) begin
            // Count down the decode timeout, fall back to start at zero
            n_timeout_left = timeout_dec;
            if (timeout_dec == '0) begin
                n_seq = ST_START;
            end
            // Update the pin from the output mode
            case (r_mode)
                MODE_HIGH: n_pin = 1'b1;
                MODE_PULSE: begin
                    if (r_pulse_left == '0) begin
                        n_pin  = 1'b0;
                        n_mode = MODE_LOW;
                    end else begin
                        n_pulse_left = r_pulse_left - CFG_W'(1);
                        n_pin        = 1'b1;
                    end
                end
                default: n_pin = 1'b0;
            endcase
        end else if (!i_item.overflow && class_code != CODE_NONE) begin
            code = class_code;
            case (r_seq)
                ST_START: begin
                    if (class_code == CODE_A) begin
                        n_seq          = ST_A;
                        n_timeout_left = r_decode_timeout;
                    end
                end
                ST_A: begin
                    // A repeated holds the state without reload
                    if (class_code != CODE_A) begin
                        n_timeout_left = r_decode_timeout;
                        if (class_code == CODE_B) begin
                            n_seq = ST_AB;
                        end else if (class_code == CODE_C) begin
                            n_seq = ST_AC;
                        end else begin
                            n_seq = ST_START;
                        end
                    end
                end
                ST_AB: begin
                    n_timeout_left = r_decode_timeout;
                    if (class_code == CODE_B) begin
                        n_seq = ST_ABB;
                    end else if (class_code == CODE_C) begin
                        n_seq = ST_ABC;
                    end else begin
                        n_seq = ST_START;
                    end
                end
                ST_AC: begin
                    n_timeout_left = r_decode_timeout;
                    if (class_code == CODE_B) begin
                        n_seq = ST_ACB;
                    end else if (class_code == CODE_C) begin
                        n_seq = ST_ACC;
                    end else begin
                        n_seq = ST_START;
                    end
                end
                default: begin
                    // Fourth code: complete the command on D, always return to start
                    n_seq = ST_START;
                    if (class_code == CODE_D) begin
                        case (r_seq)
                            ST_ABB: begin
                                n_mode = MODE_HIGH;
                                action = ACT_ON;
                            end
                            ST_ABC: begin
                                n_mode = MODE_LOW;
                                action = ACT_OFF;
                            end
                            ST_ACB: begin
                                if (r_mode != MODE_PULSE) begin
                                    n_mode       = MODE_PULSE;
                                    n_pulse_left = r_pulse_length;
                                end
                                action = ACT_PULSE;
                            end
                            default: action = ACT_RESERVED;
                        endcase
                    end
                end
            endcase
        end
    end

    // Advance the state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= ST_START;
            r_timeout_left <= DECODE_TIMEOUT_RST;
            r_mode         <= MODE_LOW;
            r_pulse_left   <= '0;
            r_pin          <= 1'b0;
        end else if (i_step) begin
            r_seq          <= n_seq;
            r_timeout_left <= n_timeout_left;
            r_mode         <= n_mode;
            r_pulse_left   <= n_pulse_left;
            r_pin          <= n_pin;
        end
    end

    // Report the merged sequence state
    always_comb begin
        o_result.code          = code;
        o_result.action        = action;
        o_result.drive         = n_pin;
        o_result.decoder_state = (n_seq == ST_ACC) ? ST_ACB : n_seq;
    end

endmodule

>>> src/pulse_width_command_decoder.sv
// Top level of the pulse width command decoder: input and result registers around the core.
// The block takes one transaction per clock cycle while o_stall is low and returns one
// result for each on o_valid. An accepted transaction waits in the input register until
// the result register can take it; then the core's classifier and sequence logic settle
// into the result register. The decoder state updates on that same edge. Results wait in
// the result register while i_stall is high. The input register keeps taking a transaction
// until it also holds one, so a stall reaches o_stall only when both registers are full.
// Configuration writes apply at the next timeout reload or pulse start.
`include "pulse_width_command_decoder_defines.svh"

module pulse_width_command_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  pwcd_pkg::t_item                  i_item,
    output logic                             o_valid,
    input  logic                             i_stall,
    output pwcd_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [pwcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwcd_pkg::CFG_W-1:0]       i_cfg_data
);
    import pwcd_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    t_cfg_wr cfg;
    logic    in_take;
    logic    step;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // Move the held transaction to the result register when that slot frees up
    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;
    assign in_take = i_valid && !o_stall;

    pwcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A command completes only on a D code
    `PWCD_ASSERT_IMPLY(a_action_needs_d, i_clk, i_rst_n,
        o_valid && o_result.action != ACT_NONE, o_result.code == CODE_D)
    // A completed command leaves the decoder at start
    `PWCD_ASSERT_IMPLY(a_action_ends_seq, i_clk, i_rst_n,
        o_valid && o_result.action != ACT_NONE, o_result.decoder_state == ST_START)
    // The two last sequence states are reported merged
    `PWCD_ASSERT_IMPLY(a_state_merged, i_clk, i_rst_n,
        o_valid, o_result.decoder_state != ST_ACC)
    // A stalled result with a full input register keeps both registers full in the next cycle
    `PWCD_ASSERT_NEXT(a_full_blocks, i_clk, i_rst_n,
        o_stall && i_stall, o_valid && r_in_valid)

endmodule
